// File: rtl/core/mexp_pkg.sv
package mexp_pkg;

    // Fixed port widths of the block
    localparam int BASE_BITS      = 32;
    localparam int EXP_PORT_BITS  = 64;
    localparam int MOD_PORT_BITS  = 32;
    localparam int POWER_BITS     = 32;

    // Defaults for the top-level parameters
    localparam int MODULUS_BITS_DEF  = 32;
    localparam int EXPONENT_BITS_DEF = 64;

endpackage

// File: rtl/core/mexp_reduce.sv
module mexp_reduce #(
    parameter int MODULUS_BITS = mexp_pkg::MODULUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mexp_pkg::BASE_BITS-1:0] i_value,
    input  logic [MODULUS_BITS-1:0]       i_modulus,
    output logic                          o_done,
    output logic [MODULUS_BITS-1:0]       o_result
);

    localparam int CW = $clog2(mexp_pkg::BASE_BITS + 1);

    logic [mexp_pkg::BASE_BITS-1:0] r_val, n_val;
    logic [MODULUS_BITS-1:0]        r_m;
    logic [MODULUS_BITS-1:0]        r_r, n_r;
    logic [CW-1:0]                  r_cnt;
    logic                           r_done;
    logic [MODULUS_BITS:0]          t;

    // One bit a step, most significant first: r = 2r + bit, then one subtract
    always_comb begin
        t = {r_r, r_val[mexp_pkg::BASE_BITS-1]};
        if (t >= {1'b0, r_m}) begin
            t = t - {1'b0, r_m};
        end
        n_r   = t[MODULUS_BITS-1:0];
        n_val = {r_val[mexp_pkg::BASE_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(mexp_pkg::BASE_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_m   <= i_modulus;
            r_r   <= '0;
        end else if (r_cnt != '0) begin
            r_val <= n_val;
            r_r   <= n_r;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

// File: rtl/core/mexp_modmul.sv
module mexp_modmul #(
    parameter int MODULUS_BITS = mexp_pkg::MODULUS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [MODULUS_BITS-1:0] i_a,
    input  logic [MODULUS_BITS-1:0] i_b,
    input  logic [MODULUS_BITS-1:0] i_modulus,
    output logic                    o_done,
    output logic [MODULUS_BITS-1:0] o_result
);

    localparam int CW = $clog2(MODULUS_BITS + 1);

    logic [MODULUS_BITS-1:0] r_a;
    logic [MODULUS_BITS-1:0] r_b;
    logic [MODULUS_BITS-1:0] r_m;
    logic [MODULUS_BITS-1:0] r_r, n_r;
    logic [CW-1:0]           r_cnt;
    logic                    r_done;
    logic [MODULUS_BITS+1:0] t;
    logic [MODULUS_BITS+1:0] m1;
    logic [MODULUS_BITS+1:0] m2;

    // Shift-add, multiplier bits most significant first: r = 2r + bit*a,
    // which stays below 3m, so compare against m and 2m in parallel
    always_comb begin
        m1 = {2'b00, r_m};
        m2 = {1'b0, r_m, 1'b0};
        t  = {1'b0, r_r, 1'b0};
        if (r_b[MODULUS_BITS-1]) begin
            t = t + {2'b00, r_a};
        end
        if (t >= m2) begin
            t = t - m2;
        end else if (t >= m1) begin
            t = t - m1;
        end
        n_r = t[MODULUS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(MODULUS_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_modulus;
            r_r <= '0;
        end else if (r_cnt != '0) begin
            r_b <= {r_b[MODULUS_BITS-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

// File: rtl/core/modular_exponentiation_top.sv
// Modular exponentiation, square-and-multiply: o_power = i_base ^ i_exponent mod i_modulus.
// Raise start with the three operands while busy is low; the item is taken at that edge and
// busy stays high until the result is out. The result appears on o_power for exactly one
// cycle with o_done high and must be captured then, as the block cannot be held off. Only
// the low EXPONENT_BITS bits of i_exponent and the low MODULUS_BITS bits of i_modulus are
// used. An exponent of zero gives 1 for every modulus; a modulus of zero, or of one with a
// nonzero exponent, gives 0. A zero exponent or modulus skips the arithmetic. Otherwise the
// run time is set by the bit-serial shift-add modular multipliers, one bit per cycle, run
// once for every exponent bit, after a bit-serial reduction of the base. A new item may be
// started in the cycle that o_done is high.
module modular_exponentiation_top #(
    parameter int MODULUS_BITS  = mexp_pkg::MODULUS_BITS_DEF,
    parameter int EXPONENT_BITS = mexp_pkg::EXPONENT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mexp_pkg::BASE_BITS-1:0]      i_base,
    input  logic [mexp_pkg::EXP_PORT_BITS-1:0]  i_exponent,
    input  logic [mexp_pkg::MOD_PORT_BITS-1:0]  i_modulus,
    output logic                                o_done,
    output logic [mexp_pkg::POWER_BITS-1:0]     o_power
);

    localparam int SW = $clog2(EXPONENT_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RED  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]               r_state;
    logic [EXPONENT_BITS-1:0] r_exp;
    logic [MODULUS_BITS-1:0]  r_m;
    logic [SW-1:0]            r_step;
    logic [MODULUS_BITS-1:0]  r_acc;
    logic [MODULUS_BITS-1:0]  r_sq;
    logic                     r_mstart;
    logic                     r_ezero;
    logic                     r_mzero;
    logic                     r_done;
    logic [mexp_pkg::POWER_BITS-1:0] r_power;

    logic                     accept;
    logic                     shortcut;
    logic [EXPONENT_BITS-1:0] in_exp;
    logic [MODULUS_BITS-1:0]  in_m;
    logic                     red_done;
    logic [MODULUS_BITS-1:0]  red_result;
    logic                     mul_done;
    logic [MODULUS_BITS-1:0]  mul_result;
    logic                     sqr_done;
    logic [MODULUS_BITS-1:0]  sqr_result;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_exp   = i_exponent[EXPONENT_BITS-1:0];
    assign in_m     = i_modulus[MODULUS_BITS-1:0];
    // Exponent or modulus zero: the answer is known at once, skip the arithmetic
    assign shortcut = (in_exp == '0) || (in_m == '0);

    // Reduce the base below the modulus before the first square
    mexp_reduce #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_reduce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept && !shortcut),
        .i_value   (i_base),
        .i_modulus (in_m),
        .o_done    (red_done),
        .o_result  (red_result)
    );

    // Accumulator times running square, taken only when the exponent bit is set
    mexp_modmul #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mstart),
        .i_a       (r_acc),
        .i_b       (r_sq),
        .i_modulus (r_m),
        .o_done    (mul_done),
        .o_result  (mul_result)
    );

    // Running square, in step with the multiply above
    mexp_modmul #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_sqr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mstart),
        .i_a       (r_sq),
        .i_b       (r_sq),
        .i_modulus (r_m),
        .o_done    (sqr_done),
        .o_result  (sqr_result)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mstart <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_done   <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= shortcut ? ST_FIN : ST_RED;
                    end
                end
                ST_RED: begin
                    // Start the first exponent step once the base is reduced
                    if (red_done) begin
                        r_state  <= ST_MUL;
                        r_mstart <= 1'b1;
                    end
                end
                ST_MUL: begin
                    if (sqr_done) begin
                        if (r_step == SW'(1)) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_mstart <= 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    // Drop the result for one cycle and free the block
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: exponent shifts out one bit per step, least significant first
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_exp   <= in_exp;
            r_m     <= in_m;
            r_ezero <= (in_exp == '0);
            r_mzero <= (in_m == '0);
        end
        if (r_state == ST_RED && red_done) begin
            r_sq   <= red_result;
            // One mod one is zero
            r_acc  <= (r_m == MODULUS_BITS'(1)) ? '0 : MODULUS_BITS'(1);
            r_step <= SW'(EXPONENT_BITS);
        end
        if (r_state == ST_MUL && sqr_done) begin
            if (r_exp[0]) begin
                r_acc <= mul_result;
            end
            r_sq   <= sqr_result;
            r_exp  <= r_exp >> 1;
            r_step <= r_step - SW'(1);
        end
        if (r_state == ST_FIN) begin
            if (r_ezero) begin
                r_power <= mexp_pkg::POWER_BITS'(1);
            end else if (r_mzero) begin
                r_power <= '0;
            end else begin
                r_power <= mexp_pkg::POWER_BITS'(r_acc);
            end
        end
    end

    assign o_done  = r_done;
    assign o_power = r_power;

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item in progress");

    // Both multipliers run in lock step
    a_units_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done == sqr_done)
        else $error("multiply and square units out of step");

    // Multipliers are started only during the exponent loop
    a_mstart_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mstart |-> (r_state == ST_MUL))
        else $error("multiplier started outside the exponent loop");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

endmodule

// File: bench/mexp_checker.sv
`timescale 1ns / 100ps

// Watches both sides of the exponentiation block, predicts each power on accept
// and compares it with the result that comes out.
module mexp_checker #(
    parameter int MODULUS_BITS  = mexp_pkg::MODULUS_BITS_DEF,
    parameter int EXPONENT_BITS = mexp_pkg::EXPONENT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [mexp_pkg::BASE_BITS-1:0]      i_base,
    input  logic [mexp_pkg::EXP_PORT_BITS-1:0]  i_exponent,
    input  logic [mexp_pkg::MOD_PORT_BITS-1:0]  i_modulus,
    input  logic                                i_done,
    input  logic [mexp_pkg::POWER_BITS-1:0]     i_power,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct {
        logic [mexp_pkg::BASE_BITS-1:0]     base;
        logic [mexp_pkg::EXP_PORT_BITS-1:0] exponent;
        logic [mexp_pkg::MOD_PORT_BITS-1:0] modulus;
        logic [mexp_pkg::POWER_BITS-1:0]    power;
    } power_due_t;

    power_due_t power_due[$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    // Square-and-multiply, LSB first; operands stay below 2^32 so products fit in 64 bits
    function automatic logic [mexp_pkg::POWER_BITS-1:0] predict_power(
        input logic [mexp_pkg::BASE_BITS-1:0]     b,
        input logic [mexp_pkg::EXP_PORT_BITS-1:0] e,
        input logic [mexp_pkg::MOD_PORT_BITS-1:0] m
    );
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] mod_used;
        logic [63:0] exp_used;
        exp_used = e & ({64{1'b1}} >> (64 - EXPONENT_BITS));
        mod_used = {32'd0, m} & ({64{1'b1}} >> (64 - MODULUS_BITS));
        if (exp_used == 64'd0)
            return 1;
        if (mod_used == 64'd0)
            return 0;
        acc = 64'd1 % mod_used;
        sq  = {32'd0, b} % mod_used;
        for (int i = 0; i < EXPONENT_BITS; i++) begin
            if (exp_used[i])
                acc = (acc * sq) % mod_used;
            sq = (sq * sq) % mod_used;
        end
        return acc[mexp_pkg::POWER_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        power_due_t due;
        if (i_rst_n) begin
            // take the result first: a new item may be accepted on the same edge
            if (i_done) begin
                if (power_due.size() == 0) begin
                    report_mismatch($sformatf("power %h with no item outstanding", i_power));
                end else begin
                    due = power_due.pop_front();
                    if (i_power !== due.power)
                        report_mismatch($sformatf("%h^%h mod %h: power %h, predicted %h",
                            due.base, due.exponent, due.modulus, i_power, due.power));
                end
            end
            if (i_start && !i_busy) begin
                due.base     = i_base;
                due.exponent = i_exponent;
                due.modulus  = i_modulus;
                due.power    = predict_power(i_base, i_exponent, i_modulus);
                power_due.insert(power_due.size(), due);
            end
        end
        o_pending <= power_due.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the exponentiation block; all checking lives in mexp_checker.
module tb_top;

    localparam int MODULUS_BITS  = mexp_pkg::MODULUS_BITS_DEF;
    localparam int EXPONENT_BITS = mexp_pkg::EXPONENT_BITS_DEF;
    localparam int RANDOM_ITEMS  = 124;
    // watchdog limit, above the run time of one item plus the longest sender gap
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 40;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [mexp_pkg::BASE_BITS-1:0]      i_base = '0;
    logic [mexp_pkg::EXP_PORT_BITS-1:0]  i_exponent = '0;
    logic [mexp_pkg::MOD_PORT_BITS-1:0]  i_modulus = '0;
    logic                                o_done;
    logic [mexp_pkg::POWER_BITS-1:0]     o_power;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    modular_exponentiation_top #(
        .MODULUS_BITS (MODULUS_BITS),
        .EXPONENT_BITS(EXPONENT_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_base    (i_base),
        .i_exponent(i_exponent),
        .i_modulus (i_modulus),
        .o_done    (o_done),
        .o_power   (o_power)
    );

    mexp_checker #(
        .MODULUS_BITS (MODULUS_BITS),
        .EXPONENT_BITS(EXPONENT_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_modulus   (i_modulus),
        .i_done      (o_done),
        .i_power     (o_power),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog: count cycles in which neither an item nor a result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one item and hold it until accepted. Start is left high, so the
    // next call goes out back to back; busy is sampled at the falling edge,
    // away from the edge where the block updates it.
    task automatic issue_item(
        input logic [mexp_pkg::BASE_BITS-1:0]     b,
        input logic [mexp_pkg::EXP_PORT_BITS-1:0] e,
        input logic [mexp_pkg::MOD_PORT_BITS-1:0] m
    );
        start      <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        i_modulus  <= m;
        @(negedge i_clk);
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Draw operands from a spread of classes: tiny and tiny-ish moduli, full
    // range, near the top, powers of two; exponents zero, short, full width.
    task automatic issue_random_item();
        logic [31:0] m;
        logic [63:0] e;
        logic [31:0] b;
        case ($urandom_range(0, 9))
            0, 1:    m = $urandom_range(1, 255);
            2:       m = $urandom_range(1, 2);
            8:       m = 32'hFFFF_FFFF - $urandom_range(0, 15);
            9:       m = 32'd1 << $urandom_range(0, 31);
            default: m = $urandom;
        endcase
        case ($urandom_range(0, 15))
            0:       e = '0;
            1, 2, 3: e = 64'($urandom_range(1, 1000));
            4:       e = {1'b1, 31'($urandom), 32'($urandom)};
            5:       e = 64'($urandom);
            default: e = {32'($urandom), 32'($urandom)};
        endcase
        case ($urandom_range(0, 7))
            0:       b = '0;
            1:       b = m - 1;
            2:       b = m + $urandom_range(0, 1000);
            default: b = $urandom;
        endcase
        issue_item(b, e, m);
    endtask

    initial begin
        int sent;
        int burst;
        int gap;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero exponent (also with modulus one and zero), modulus one,
        // zero modulus, base above modulus, field extremes, a Fermat identity
        issue_item(32'd7,          64'd0,                  32'd1);
        issue_item(32'd0,          64'd0,                  32'd13);
        issue_item(32'hFFFF_FFFF,  64'd0,                  32'hFFFF_FFFF);
        issue_item(32'd12345,      64'd0,                  32'd0);
        issue_item(32'd12345,      64'd99,                 32'd0);
        issue_item(32'hDEAD_BEEF,  64'd5,                  32'd1);
        issue_item(32'd0,          64'd3,                  32'd97);
        issue_item(32'd1000,       64'd1,                  32'd7);
        issue_item(32'hFFFF_FFFF,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        issue_item(32'hFFFF_FFFE,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFB);
        issue_item(32'd2,          64'd4294967290,         32'd4294967291);
        issue_item(32'd3,          64'h8000_0000_0000_0000, 32'd1000003);
        issue_item(32'd3,          64'd1,                  32'd2);
        issue_item(32'hAAAA_AAAA,  64'h5555_5555_5555_5555, 32'h8000_0000);
        issue_item(32'h5555_5555,  64'hAAAA_AAAA_AAAA_AAAA, 32'h7FFF_FFFF);
        issue_item(32'd4,          64'd13,                 32'd497);

        // Random part: bursts of back-to-back items, then gaps of varying depth
        // with junk on the operand lines that the block must ignore
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                issue_random_item();
                sent++;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(100, 3000);
                default: gap = $urandom_range(1, 40);
            endcase
            for (int k = 0; k < gap; k++) begin
                start      <= 1'b0;
                i_base     <= $urandom;
                i_exponent <= {32'($urandom), 32'($urandom)};
                i_modulus  <= $urandom;
                @(posedge i_clk);
            end
        end
        start <= 1'b0;

        // Drain: wait out every outstanding power, then a short margin
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
